// ----- rtl/pctdec_pkg.sv -----
// ---------------------------------------------------------------------------
// pctdec_pkg: shared types and constants for the percent decoder
// Holds the character codes, the command beat that travels from the front
// end to the back end, the escape state type and the hex digit decoder.
// ---------------------------------------------------------------------------
package pctdec_pkg;

    // Character codes used by the escape parser.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DIG_0   = 8'h30;
    localparam logic [7:0] CH_DIG_9   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

    // Command queue between front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Escape parser state.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_HIGH
    } phase_t;

    // What the back end has to do with a command beat.
    typedef enum logic [1:0] {
        OP_PASS,
        OP_DECODE,
        OP_ERROR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [3:0] hi_nibble;
        logic [3:0] lo_nibble;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    // Classify one byte as a hex digit (either case) and give its value.
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t       r;
        logic [7:0] d;
        r.valid = 1'b1;
        d       = 8'd0;
        if (c inside {[CH_UPPER_A:CH_UPPER_F]})
        begin
            d = c - CH_UPPER_A + HEX_ALPHA_BASE;
        end
        else if (c inside {[CH_LOWER_A:CH_LOWER_F]})
        begin
            d = c - CH_LOWER_A + HEX_ALPHA_BASE;
        end
        else if (c inside {[CH_DIG_0:CH_DIG_9]})
        begin
            d = c - CH_DIG_0;
        end
        else
        begin
            r.valid = 1'b0;
        end
        r.value = d[3:0];
        return r;
    endfunction

endpackage

// ----- rtl/pctdec_front.sv -----
// ---------------------------------------------------------------------------
// pctdec_front: escape parser of the percent decoder
// Takes one input beat per cycle while accept is high, tracks the percent escape and the discard
// state, and writes one command beat per result into the command queue.
// ---------------------------------------------------------------------------
module pctdec_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                end_of_string,
    output logic                wr_en,
    output pctdec_pkg::cmd_t    wr_cmd
);

    pctdec_pkg::phase_t phase_reg;
    pctdec_pkg::phase_t phase_next;
    logic [3:0]         high_nibble_reg;
    logic [3:0]         high_nibble_next;
    logic               discard_reg;
    logic               discard_next;
    pctdec_pkg::hex_t   hex;

    // Decode the incoming byte as a hex digit.
    assign hex = pctdec_pkg::hex_decode(in_byte);

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= pctdec_pkg::PH_IDLE;
            high_nibble_reg <= 4'd0;
            discard_reg     <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            discard_reg     <= discard_next;
        end
    end

    // Next state and command generation.
    always_comb
    begin
        logic fail;
        fail             = 1'b0;
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        discard_next     = discard_reg;
        wr_en            = 1'b0;
        wr_cmd.op        = pctdec_pkg::OP_PASS;
        wr_cmd.data      = in_byte;
        wr_cmd.hi_nibble = 4'd0;
        wr_cmd.lo_nibble = 4'd0;
        wr_cmd.last      = end_of_string;

        if (accept)
        begin
            if (discard_reg)
            begin
                // Drop bytes until the end of the broken string.
                if (end_of_string)
                begin
                    discard_next = 1'b0;
                end
            end
            else
            begin
                case (phase_reg)
                    pctdec_pkg::PH_PCT:
                    begin
                        if (!hex.valid || end_of_string)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            high_nibble_next = hex.value;
                            phase_next       = pctdec_pkg::PH_HIGH;
                        end
                    end
                    pctdec_pkg::PH_HIGH:
                    begin
                        if (!hex.valid)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            wr_cmd.op        = pctdec_pkg::OP_DECODE;
                            wr_cmd.hi_nibble = high_nibble_reg;
                            wr_cmd.lo_nibble = hex.value;
                            phase_next       = pctdec_pkg::PH_IDLE;
                            high_nibble_next = 4'd0;
                        end
                    end
                    default:
                    begin
                        phase_next = pctdec_pkg::PH_IDLE;
                        if (in_byte == pctdec_pkg::CH_PERCENT)
                        begin
                            if (end_of_string)
                            begin
                                fail = 1'b1;
                            end
                            else
                            begin
                                phase_next = pctdec_pkg::PH_PCT;
                            end
                        end
                        else
                        begin
                            wr_en = 1'b1;
                        end
                    end
                endcase

                // A bad digit or a cut-off escape ends the string with an error.
                if (fail)
                begin
                    wr_en            = 1'b1;
                    wr_cmd.op        = pctdec_pkg::OP_ERROR;
                    wr_cmd.data      = 8'd0;
                    wr_cmd.last      = 1'b1;
                    phase_next       = pctdec_pkg::PH_IDLE;
                    high_nibble_next = 4'd0;
                    discard_next     = !end_of_string;
                end
            end
        end
    end

    // An error result always closes the string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && wr_cmd.op == pctdec_pkg::OP_ERROR) |-> wr_cmd.last)
        else $error("error command without last flag");

    // An error on a byte that is not final starts discarding.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && wr_cmd.op == pctdec_pkg::OP_ERROR && !end_of_string) |=> discard_reg)
        else $error("discard not entered after error");

    // While discarding, no escape is pending and nothing is written.
    assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> (phase_reg == pctdec_pkg::PH_IDLE && !wr_en))
        else $error("activity while discarding");

endmodule

// ----- rtl/pctdec_queue.sv -----
// ---------------------------------------------------------------------------
// pctdec_queue: command queue between front and back end
// A short register queue that lets the parser keep taking bytes while the
// result side stalls.
// ---------------------------------------------------------------------------
module pctdec_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  pctdec_pkg::cmd_t    wr_cmd,
    output logic                full,
    input  logic                rd_en,
    output logic                rd_valid,
    output pctdec_pkg::cmd_t    rd_cmd
);

    localparam logic [pctdec_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        pctdec_pkg::QUEUE_PTR_W'(pctdec_pkg::QUEUE_DEPTH - 1);
    localparam logic [pctdec_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        pctdec_pkg::QUEUE_CNT_W'(pctdec_pkg::QUEUE_DEPTH);

    pctdec_pkg::cmd_t                     slot_reg [pctdec_pkg::QUEUE_DEPTH];
    logic [pctdec_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [pctdec_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [pctdec_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic [pctdec_pkg::QUEUE_CNT_W-1:0]   count_next;
    logic                                 do_wr;
    logic                                 do_rd;

    assign full     = (count_reg == CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Occupancy follows the writes and reads of this cycle.
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage slots hold payload only.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // Occupancy never passes the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue occupancy out of range");

    // A write into a full queue would lose a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("command written into full queue");

endmodule

// ----- rtl/pctdec_back.sv -----
// ---------------------------------------------------------------------------
// pctdec_back: result stage of the percent decoder
// Pulls command beats from the queue, forms the result byte and holds it in
// an output register until the consumer pops it.
// ---------------------------------------------------------------------------
module pctdec_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_valid,
    input  pctdec_pkg::cmd_t    rd_cmd,
    output logic                rd_en,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          out_byte,
    output logic                is_last,
    output logic                decode_error
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       is_last_reg;
    logic       error_reg;
    logic       load;

    // Take a new command when the output register is free or being popped.
    assign load  = rd_valid && (!out_valid_reg || pop);
    assign rd_en = load;
    assign empty = !out_valid_reg;

    // Form the result byte from the command.
    always_comb
    begin
        case (rd_cmd.op)
            pctdec_pkg::OP_PASS:   out_byte_next = rd_cmd.data;
            pctdec_pkg::OP_DECODE: out_byte_next = {rd_cmd.hi_nibble, rd_cmd.lo_nibble};
            default:               out_byte_next = 8'd0;
        endcase
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= out_byte_next;
            is_last_reg  <= rd_cmd.last;
            error_reg    <= (rd_cmd.op == pctdec_pkg::OP_ERROR);
        end
    end

    assign out_byte     = out_byte_reg;
    assign is_last      = is_last_reg;
    assign decode_error = error_reg;

    // An error result carries a zero byte and closes the string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && error_reg) |-> (out_byte_reg == 8'd0 && is_last_reg))
        else $error("malformed error result");

endmodule

// ----- rtl/percent_decoder_unit.sv -----
// ---------------------------------------------------------------------------
// percent_decoder_unit: URL percent decoder, one byte per cycle while not full
// A result beat is written into the queue at the edge that accepts its last
// input beat, and is loaded into the output register once that register is
// free or being popped; the parser itself is combinational.
// Throughput: one input beat per cycle while the queue is not full; the
// four-entry queue absorbs output stalls.
// Reset: asynchronous, active low; no escape pending, not discarding, empty.
// ---------------------------------------------------------------------------
module percent_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    input  logic       push,
    output logic       full,
    output logic [7:0] out_byte,
    output logic       is_last,
    output logic       decode_error,
    output logic       empty,
    input  logic       pop
);

    logic             accept;
    logic             wr_en;
    pctdec_pkg::cmd_t wr_cmd;
    logic             rd_en;
    logic             rd_valid;
    pctdec_pkg::cmd_t rd_cmd;

    // An input beat is taken whenever the queue has room.
    assign accept = push && !full;

    pctdec_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .wr_en         (wr_en),
        .wr_cmd        (wr_cmd)
    );

    pctdec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_cmd   (wr_cmd),
        .full     (full),
        .rd_en    (rd_en),
        .rd_valid (rd_valid),
        .rd_cmd   (rd_cmd)
    );

    pctdec_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_valid     (rd_valid),
        .rd_cmd       (rd_cmd),
        .rd_en        (rd_en),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .is_last      (is_last),
        .decode_error (decode_error)
    );

endmodule
